[hw/rtl/cse_pkg.sv]
// Shared types, codes and constants for the CAN signal extractor.
// Used by can_signal_extractor_top. No dependencies.
`timescale 1ns / 1ps

package cse_pkg;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);

  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned START_W  = 9;
  localparam int unsigned LENGTH_W = 6;
  localparam int unsigned ORDER_W  = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // A signal of up to 32 bits touches at most five bytes.
  localparam int unsigned WIN_BYTES = 5;
  localparam int unsigned WIN_W     = WIN_BYTES * BYTE_W;

  localparam logic [9:0]          FRAME_LIMIT = 10'(FRAME_BYTES);
  localparam logic [LENGTH_W-1:0] MAX_LENGTH  = LENGTH_W'(VALUE_W);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [ORDER_W-1:0] {
    ORD_INTEL    = 2'd0,
    ORD_MOTO_LSB = 2'd1,
    ORD_MOTO_MSB = 2'd2,
    ORD_BAD      = 2'd3
  } order_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  function automatic logic [VALUE_W-1:0] low_mask(input logic [LENGTH_W-1:0] len);
    logic [VALUE_W-1:0] mask;
    mask = '0;
    if (len != '0) begin
      mask = {VALUE_W{1'b1}} >> (MAX_LENGTH - len);
    end
    return mask;
  endfunction

endpackage

[hw/rtl/cse_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/can_signal_extractor_top.sv]
// Top level of the CAN signal extractor: frame store, byte sequencer and result register.
// Depends on cse_pkg and cse_ram.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------------------------------
//   input   | in_valid_i  | in_stall_o  | command_i byte_index_i byte_value_i start_bit_i
//           |             |             | bit_length_i byte_order_i timed_out_i
//           |             |             | use_invalid_i invalid_value_i
//   output  | out_valid_o | out_stall_i | value_o status_o
//
// A load, a zero-length extract, or an extract that ends in a timeout, format or range status
// is answered from the idle state. An extract that reads n frame bytes (n is 1 to 5) goes
// through the read state, on the single registered read port of the frame RAM, which returns
// one byte per cycle in the cycle after its address, and then through the shift state.
// Reset clears the sequencer and the result register; the frame store is not cleared.
// A result that waits on out_stall_i holds off every input transfer until it is taken.
`timescale 1ns / 1ps

module can_signal_extractor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [cse_pkg::INDEX_W-1:0]     byte_index_i,
  input  logic [cse_pkg::BYTE_W-1:0]      byte_value_i,
  input  logic [cse_pkg::START_W-1:0]     start_bit_i,
  input  logic [cse_pkg::LENGTH_W-1:0]    bit_length_i,
  input  logic [cse_pkg::ORDER_W-1:0]     byte_order_i,
  input  logic                            timed_out_i,
  input  logic                            use_invalid_i,
  input  logic [cse_pkg::VALUE_W-1:0]     invalid_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cse_pkg::VALUE_W-1:0]     value_o,
  output logic [cse_pkg::STATUS_W-1:0]    status_o
);

  import cse_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_e;

  state_e               state_q, state_d;
  order_e               order_q, order_d;
  logic [5:0]           base_q, base_d;
  logic [2:0]           span_q, span_d;
  logic [2:0]           iss_q, iss_d;
  logic [LENGTH_W-1:0]  len_q, len_d;
  logic [5:0]           shift_q, shift_d;
  logic [WIN_W-1:0]     window_q, window_d;
  logic                 out_vld_q, out_vld_d;
  logic [VALUE_W-1:0]   value_q, value_d;
  status_e              status_q, status_d;

  logic                 in_accept;
  logic                 out_free;
  logic                 ram_we;
  logic [BYTE_W-1:0]    ram_rdata;
  logic [5:0]           rd_byte;

  logic [5:0]           start_byte;
  logic [2:0]           start_off;
  logic [9:0]           len_ext;
  logic [9:0]           intel_last;
  logic [9:0]           lsb_span;
  logic [9:0]           msb_span;
  logic                 bad_format;
  logic                 start_out;
  logic                 span_bad;
  logic [2:0]           cap_idx;
  logic [2:0]           cap_slot;
  logic [WIN_W-1:0]     window_shifted;

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign start_byte = start_bit_i[8:3];
  assign start_off  = start_bit_i[2:0];
  assign len_ext    = {4'b0, bit_length_i};
  assign intel_last = ({1'b0, start_bit_i} + len_ext - 10'd1) >> 3;
  assign lsb_span   = ({7'b0, start_off} + len_ext - 10'd1) >> 3;
  assign msb_span   = (10'd7 - {7'b0, start_off} + len_ext - 10'd1) >> 3;

  assign bad_format = (byte_order_i == ORD_BAD) || (bit_length_i > MAX_LENGTH);
  assign start_out  = {4'b0, start_byte} >= FRAME_LIMIT;

  always_comb begin
    case (byte_order_i)
      ORD_INTEL:    span_bad = intel_last >= FRAME_LIMIT;
      ORD_MOTO_LSB: span_bad = lsb_span > {4'b0, start_byte};
      default:      span_bad = ({4'b0, start_byte} + msb_span) >= FRAME_LIMIT;
    endcase
  end

  assign ram_we = in_accept && (command_i == CMD_LOAD)
                  && ({4'b0, byte_index_i} < FRAME_LIMIT);

  assign rd_byte = (order_q == ORD_MOTO_LSB) ? (base_q - {3'b0, iss_q})
                                             : (base_q + {3'b0, iss_q});

  assign cap_idx  = iss_q - 3'd1;
  assign cap_slot = (order_q == ORD_MOTO_MSB) ? (3'(WIN_BYTES - 1) - cap_idx) : cap_idx;

  assign window_shifted = window_q >> shift_q;

  cse_ram #(
    .Width (BYTE_W),
    .Depth (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(byte_index_i)),
    .wdata_i (byte_value_i),
    .raddr_i (ADDR_W'(rd_byte)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    order_d   = order_q;
    base_d    = base_q;
    span_d    = span_q;
    iss_d     = iss_q;
    len_d     = len_q;
    shift_d   = shift_q;
    window_d  = window_q;
    out_vld_d = out_vld_q;
    value_d   = value_q;
    status_d  = status_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          out_vld_d = 1'b1;
          value_d   = '0;
          status_d  = ST_OK;
          if (command_i == CMD_LOAD) begin
            status_d = ST_OK;
          end else if (timed_out_i && use_invalid_i) begin
            value_d  = invalid_value_i;
            status_d = ST_TIMEOUT;
          end else if (bad_format) begin
            status_d = ST_FORMAT;
          end else if (start_out) begin
            status_d = ST_RANGE;
          end else if (bit_length_i == '0) begin
            status_d = ST_OK;
          end else if (span_bad) begin
            status_d = ST_RANGE;
          end else begin
            out_vld_d = 1'b0;
            state_d   = S_READ;
            order_d   = order_e'(byte_order_i);
            base_d    = start_byte;
            iss_d     = '0;
            len_d     = bit_length_i;
            if (byte_order_i == ORD_MOTO_MSB) begin
              span_d  = msb_span[2:0];
              shift_d = 6'(7'd33 + {4'b0, start_off} - {1'b0, bit_length_i});
            end else begin
              span_d  = lsb_span[2:0];
              shift_d = {3'b0, start_off};
            end
          end
        end
      end
      S_READ: begin
        if (iss_q != '0) begin
          window_d[{cap_slot, 3'b000} +: BYTE_W] = ram_rdata;
        end
        if (iss_q == span_q + 3'd1) begin
          state_d = S_SHIFT;
        end else begin
          iss_d = iss_q + 3'd1;
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          value_d   = window_shifted[VALUE_W-1:0] & low_mask(len_q);
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      order_q   <= ORD_INTEL;
      base_q    <= '0;
      span_q    <= '0;
      iss_q     <= '0;
      len_q     <= '0;
      shift_q   <= '0;
      window_q  <= '0;
      out_vld_q <= 1'b0;
      value_q   <= '0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      order_q   <= order_d;
      base_q    <= base_d;
      span_q    <= span_d;
      iss_q     <= iss_d;
      len_q     <= len_d;
      shift_q   <= shift_d;
      window_q  <= window_d;
      out_vld_q <= out_vld_d;
      value_q   <= value_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> (span_q <= 3'(WIN_BYTES - 1)) && (iss_q <= span_q + 3'd1))
    else $error("Byte sequencer ran past the signal span.");

  a_shift_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) && out_free |=> out_vld_q && (state_q == S_IDLE))
    else $error("Shift step did not post its result.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ((status_q == ST_FORMAT) || (status_q == ST_RANGE)) |-> value_q == '0)
    else $error("Error status carries a nonzero value.");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE)
    else $error("Frame store written while an extract is in progress.");

endmodule

[tb/can_signal_extractor_checker.sv]
// Checker for the CAN signal extractor: watches both channels, keeps a copy of the frame store
// and compares each result transfer with its prediction. Depends on cse_pkg.
`timescale 1ns / 1ps

module can_signal_extractor_checker
  import cse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [INDEX_W-1:0]    byte_index_i,
  input  logic [BYTE_W-1:0]     byte_value_i,
  input  logic [START_W-1:0]    start_bit_i,
  input  logic [LENGTH_W-1:0]   bit_length_i,
  input  logic [ORDER_W-1:0]    byte_order_i,
  input  logic                  timed_out_i,
  input  logic                  use_invalid_i,
  input  logic [VALUE_W-1:0]    invalid_value_i,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [VALUE_W-1:0]    value_o,
  input  logic [STATUS_W-1:0]   status_o,
  output int unsigned           error_count,
  output int unsigned           pending_count
);

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            status;
  } signal_result_t;

  logic [BYTE_W-1:0] frame_mirror [FRAME_BYTES];
  signal_result_t    signal_results_q [$];
  int unsigned       mismatch_total = 0;
  int unsigned       outstanding = 0;

  assign error_count   = mismatch_total;
  assign pending_count = outstanding;

  function automatic signal_result_t unpack_signal(input logic [START_W-1:0] start_bit,
                                                   input logic [LENGTH_W-1:0] bit_length,
                                                   input logic [ORDER_W-1:0] byte_order,
                                                   input logic timed_out, input logic use_invalid,
                                                   input logic [VALUE_W-1:0] invalid_value);
    signal_result_t res;
    int s;
    int len;
    int b;
    int off;
    int p;
    int k;
    s = int'(start_bit);
    len = int'(bit_length);
    b = s >> 3;
    off = s & 7;
    res.value = '0;
    res.status = ST_OK;
    if (timed_out && use_invalid) begin
      res.value = invalid_value;
      res.status = ST_TIMEOUT;
    end else if (byte_order == ORD_BAD || len > int'(VALUE_W)) begin
      res.status = ST_FORMAT;
    end else if (b >= int'(FRAME_BYTES)) begin
      res.status = ST_RANGE;
    end else if (len != 0) begin
      case (byte_order)
        ORD_INTEL: begin
          if (((s + len - 1) >> 3) >= int'(FRAME_BYTES)) begin
            res.status = ST_RANGE;
          end else begin
            for (k = 0; k < len; k++) begin
              p = s + k;
              res.value[k] = frame_mirror[p >> 3][p & 7];
            end
          end
        end
        ORD_MOTO_LSB: begin
          if (((off + len - 1) >> 3) > b) begin
            res.status = ST_RANGE;
          end else begin
            for (k = 0; k < len; k++) begin
              p = off + k;
              res.value[k] = frame_mirror[b - (p >> 3)][p & 7];
            end
          end
        end
        default: begin
          if (b + ((7 - off + len - 1) >> 3) >= int'(FRAME_BYTES)) begin
            res.status = ST_RANGE;
          end else begin
            for (k = 0; k < len; k++) begin
              p = 7 - off + k;
              res.value = {res.value[VALUE_W-2:0], frame_mirror[b + (p >> 3)][7 - (p & 7)]};
            end
          end
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    signal_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (signal_results_q.size() == 0) begin
          $display("%0t: result with none outstanding: expected none, got value=%h status=%0d",
                   $time, value_o, status_o);
          mismatch_total++;
        end else begin
          want = signal_results_q.pop_front();
          if (value_o !== want.value) begin
            $display("%0t: value mismatch: expected %h, got %h", $time, want.value, value_o);
            mismatch_total++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status_o);
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (command_i == CMD_LOAD) begin
          if (int'(byte_index_i) < int'(FRAME_BYTES)) begin
            frame_mirror[byte_index_i] = byte_value_i;
          end
          want.value = '0;
          want.status = ST_OK;
        end else begin
          want = unpack_signal(start_bit_i, bit_length_i, byte_order_i, timed_out_i,
                               use_invalid_i, invalid_value_i);
        end
        signal_results_q.push_back(want);
      end
      outstanding = signal_results_q.size();
    end
  end

endmodule

[tb/tb_can_signal_extractor_top.sv]
// Testbench top for the CAN signal extractor: clock, reset, frame loads and signal extracts,
// random idling on both channels and the verdict. Depends on cse_pkg, the block and its checker.
`timescale 1ns / 1ps

module tb_can_signal_extractor_top;
  import cse_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1725;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  command_i;
  logic [INDEX_W-1:0]    byte_index_i;
  logic [BYTE_W-1:0]     byte_value_i;
  logic [START_W-1:0]    start_bit_i;
  logic [LENGTH_W-1:0]   bit_length_i;
  logic [ORDER_W-1:0]    byte_order_i;
  logic                  timed_out_i;
  logic                  use_invalid_i;
  logic [VALUE_W-1:0]    invalid_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VALUE_W-1:0]    value_o;
  logic [STATUS_W-1:0]   status_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;
  logic        hold_request = 1'b0;
  logic        byte_written [FRAME_BYTES];

  can_signal_extractor_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .byte_index_i, .byte_value_i,
    .start_bit_i, .bit_length_i, .byte_order_i, .timed_out_i, .use_invalid_i,
    .invalid_value_i, .out_valid_o, .out_stall_i, .value_o, .status_o
  );

  can_signal_extractor_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .byte_index_i, .byte_value_i,
    .start_bit_i, .bit_length_i, .byte_order_i, .timed_out_i, .use_invalid_i,
    .invalid_value_i, .out_valid_o, .out_stall_i, .value_o, .status_o,
    .error_count, .pending_count
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  // Returns the first frame byte that an extract would read before it was ever loaded.
  function automatic int first_unwritten(input logic [ORDER_W-1:0] order,
                                         input logic [START_W-1:0] start_bit,
                                         input logic [LENGTH_W-1:0] bit_length,
                                         input logic timed_out, input logic use_invalid);
    int s;
    int len;
    int lo;
    int hi;
    int i;
    s = int'(start_bit);
    len = int'(bit_length);
    lo = s >> 3;
    hi = s >> 3;
    if ((timed_out && use_invalid) || order == ORD_BAD || len > int'(VALUE_W)) begin
      return -1;
    end
    if (len != 0) begin
      case (order)
        ORD_INTEL:    hi = (s + len - 1) >> 3;
        ORD_MOTO_LSB: lo = lo - (((s & 7) + len - 1) >> 3);
        default:      hi = hi + ((7 - (s & 7) + len - 1) >> 3);
      endcase
    end
    if (lo < 0) lo = 0;
    if (hi > int'(FRAME_BYTES) - 1) hi = int'(FRAME_BYTES) - 1;
    for (i = lo; i <= hi; i++) begin
      if (!byte_written[i]) return i;
    end
    return -1;
  endfunction

  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic [BYTE_W-1:0] data, input logic [START_W-1:0] start_bit,
                           input logic [LENGTH_W-1:0] bit_length,
                           input logic [ORDER_W-1:0] order, input logic timed_out,
                           input logic use_invalid, input logic [VALUE_W-1:0] invalid_value);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (cmd == CMD_LOAD) byte_written[idx] = 1'b1;
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    byte_index_i    <= idx;
    byte_value_i    <= data;
    start_bit_i     <= start_bit;
    bit_length_i    <= bit_length;
    byte_order_i    <= order;
    timed_out_i     <= timed_out;
    use_invalid_i   <= use_invalid;
    invalid_value_i <= invalid_value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    logic                cmd;
    logic [INDEX_W-1:0]  idx;
    logic [BYTE_W-1:0]   data;
    logic [START_W-1:0]  start_bit;
    logic [LENGTH_W-1:0] bit_length;
    logic [ORDER_W-1:0]  order;
    logic                timed_out;
    logic                use_invalid;
    logic [VALUE_W-1:0]  invalid_value;
    int                  pick;
    int                  gap;
    int                  n;

    foreach (byte_written[i]) byte_written[i] = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_LOAD;
    byte_index_i = '0;
    byte_value_i = '0;
    start_bit_i = '0;
    bit_length_i = '0;
    byte_order_i = ORD_INTEL;
    timed_out_i = 1'b0;
    use_invalid_i = 1'b0;
    invalid_value_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(CMD_LOAD, 6'd0, 8'hA5, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd1, 8'h3C, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd2, 8'hFF, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd3, 8'h00, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd4, 8'h81, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd62, 8'h5A, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_LOAD, 6'd63, 8'hFF, '0, '0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd32, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd0, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd504, 6'd8, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd505, 6'd8, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd511, 6'd1, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd8, ORD_MOTO_LSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd1, 6'd8, ORD_MOTO_LSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd39, 6'd32, ORD_MOTO_LSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd37, 6'd32, ORD_MOTO_LSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd7, 6'd32, ORD_MOTO_MSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd511, 6'd8, ORD_MOTO_MSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd504, 6'd2, ORD_MOTO_MSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd16, 6'd8, ORD_BAD, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd33, ORD_INTEL, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd63, ORD_MOTO_MSB, 1'b0, 1'b0, '0);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd8, ORD_BAD, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd8, ORD_INTEL, 1'b1, 1'b0, 32'h1234_5678);
    send_item(CMD_EXTRACT, '0, '0, 9'd0, 6'd8, ORD_INTEL, 1'b0, 1'b1, 32'h8765_4321);
    wait_drained();

    for (n = 0; n < int'(RANDOM_ITEMS); n++) begin
      calm = (n >= 500 && n < 800);
      if (n == 900) hold_request = 1'b1;
      if (n == 1200) wait_drained();
      cmd = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_EXTRACT;
      idx = INDEX_W'($urandom);
      data = BYTE_W'($urandom);
      start_bit = START_W'($urandom);
      timed_out = ($urandom_range(99) < 30);
      use_invalid = 1'($urandom);
      invalid_value = $urandom;
      pick = $urandom_range(99);
      if (pick < 30) order = ORD_INTEL;
      else if (pick < 60) order = ORD_MOTO_LSB;
      else if (pick < 90) order = ORD_MOTO_MSB;
      else order = ORD_BAD;
      pick = $urandom_range(99);
      if (pick < 8) bit_length = LENGTH_W'($urandom_range(63, 33));
      else if (pick < 13) bit_length = '0;
      else if (pick < 20) bit_length = LENGTH_W'(VALUE_W);
      else bit_length = LENGTH_W'($urandom_range(31, 1));
      if (cmd == CMD_EXTRACT) begin
        // Load a byte the extract would need first, so that no unloaded byte is ever read.
        gap = first_unwritten(order, start_bit, bit_length, timed_out, use_invalid);
        if (gap >= 0) begin
          cmd = CMD_LOAD;
          idx = INDEX_W'(gap);
        end
      end
      send_item(cmd, idx, data, start_bit, bit_length, order, timed_out, use_invalid,
                invalid_value);
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cse_pkg.sv
hw/rtl/cse_ram.sv
hw/rtl/can_signal_extractor_top.sv
tb/can_signal_extractor_checker.sv
tb/tb_can_signal_extractor_top.sv
